// ===== hw/rtl/wtst_pkg.sv =====
// ----------------------------------------------------------------------------
// wtst_pkg: shared types and constants of the weekly time switch table
// Item layouts, operation codes, sequencer states and time helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package wtst_pkg;

    // Table geometry
    localparam int MAX_ENTRIES = 32;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    // Time value: day * 1440 + hour * 60 + minute, at most 10563
    localparam int TIME_W = 14;
    localparam logic [TIME_W-1:0] MIN_PER_HOUR = TIME_W'(60);
    localparam logic [TIME_W-1:0] MIN_PER_DAY  = TIME_W'(60 * 24);
    localparam logic [2:0]        DAY_ALIAS    = 3'd7;

    // Operation codes
    typedef enum logic [1:0] {
        OP_APPEND    = 2'd0,
        OP_TICK      = 2'd1,
        OP_RECOMPUTE = 2'd2
    } op_t;

    // Sequencer states
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_SCAN = 1'b1
    } state_t;

    // Input item
    typedef struct packed {
        logic [1:0] operation;
        logic [2:0] day;
        logic [4:0] hour;
        logic [5:0] minute;
        logic       entry_event;
    } in_item_t;

    // Result item
    typedef struct packed {
        logic fired;
        logic fired_event;
        logic condition;
        logic entry_added;
    } out_item_t;

    // Stored table entry
    typedef struct packed {
        logic [2:0] day;
        logic [4:0] hour;
        logic [5:0] minute;
        logic       ev;
    } entry_t;

    // Day seven is sunday
    function automatic logic [2:0] norm_day(input logic [2:0] d);
        return (d == DAY_ALIAS) ? 3'd0 : d;
    endfunction

    // Minutes since start of day, or of week in weekly mode
    function automatic logic [TIME_W-1:0] time_of(
        input logic       weekly,
        input logic [2:0] d,
        input logic [4:0] h,
        input logic [5:0] m
    );
        logic [TIME_W-1:0] t;
        t = TIME_W'(h) * MIN_PER_HOUR + TIME_W'(m);
        if (weekly)
        begin
            t = t + TIME_W'(d) * MIN_PER_DAY;
        end
        return t;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/weekly_time_switch_table_unit.sv =====
// ----------------------------------------------------------------------------
// weekly_time_switch_table_unit: table of weekly switch times
// Appends entries, matches minute ticks and recomputes the on/off condition
// by walking the stored entries one per cycle through one compare unit.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken at a rising edge with start high and busy low. Every
//   item gives exactly one result, shown on result for one cycle with done
//   high; the receiver cannot stall it and must take it in that cycle.
//   Append, unused operation code and a tick or recompute on an empty
//   table: done in the cycle after the item is taken, busy stays low, so such
//   items can follow every cycle.
//   Tick and recompute read the table memory one entry per cycle through
//   its registered read port and hold busy high until the last stored
//   entry is checked (or a tick hits early); the next item can be
//   taken once busy is low again, not while the scan runs.
//   schedule_mode is written through cfg_we / cfg_wdata; the user must do
//   so only while idle, as the block does not enforce it. Reset clears the
//   entry count, the condition and schedule_mode; the table memory itself
//   is not cleared, entries past the count are never read.
// ----------------------------------------------------------------------------
`default_nettype none

module weekly_time_switch_table_unit
    import wtst_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    output logic           busy,
    input  wire in_item_t  in_item,
    input  wire logic      cfg_we,
    input  wire logic      cfg_wdata,
    output logic           done,
    output out_item_t      result
);

    // Table memory
    entry_t mem [MAX_ENTRIES];
    entry_t rd_data_reg;

    // Control state
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  rd_idx_reg, rd_idx_next;
    logic              pend_reg, pend_next;
    logic              cond_reg, cond_next;
    logic              mode_reg;
    logic              found_reg, found_next;
    logic              done_reg, done_next;

    // Payload state
    logic              is_tick_reg, is_tick_next;
    logic [2:0]        d_reg, d_next;
    logic [4:0]        h_reg, h_next;
    logic [5:0]        m_reg, m_next;
    logic [TIME_W-1:0] now_reg, now_next;
    logic [TIME_W-1:0] best_reg, best_next;
    logic              best_ev_reg, best_ev_next;
    out_item_t         result_reg, result_next;

    // Memory access
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    entry_t            wr_data;
    logic [IDX_W-1:0]  rd_addr;

    logic              accept;
    logic [2:0]        in_day;
    logic              table_full;
    logic              issue;
    logic              tick_hit;
    logic [TIME_W-1:0] ent_time;
    logic              qualify;

    assign accept     = start && (state_reg == ST_IDLE);
    assign in_day     = norm_day(in_item.day);
    assign table_full = (count_reg >= CNT_W'(MAX_ENTRIES));
    assign rd_addr    = rd_idx_reg[IDX_W-1:0];
    assign issue      = (rd_idx_reg < count_reg);

    // Shared compare unit on the entry read last cycle
    assign tick_hit = (rd_data_reg.hour == h_reg) && (rd_data_reg.minute == m_reg)
                      && (!mode_reg || (rd_data_reg.day == d_reg));
    assign ent_time = time_of(mode_reg, rd_data_reg.day, rd_data_reg.hour,
                              rd_data_reg.minute);
    assign qualify  = (ent_time < now_reg) && (!found_reg || (ent_time > best_reg));

    // Next state and outputs
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        rd_idx_next  = rd_idx_reg;
        pend_next    = 1'b0;
        cond_next    = cond_reg;
        found_next   = found_reg;
        done_next    = 1'b0;
        is_tick_next = is_tick_reg;
        d_next       = d_reg;
        h_next       = h_reg;
        m_next       = m_reg;
        now_next     = now_reg;
        best_next    = best_reg;
        best_ev_next = best_ev_reg;
        result_next  = result_reg;
        wr_en        = 1'b0;
        wr_addr      = count_reg[IDX_W-1:0];
        wr_data      = '{day: in_day, hour: in_item.hour, minute: in_item.minute,
                         ev: in_item.entry_event};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    is_tick_next = (in_item.operation == OP_TICK);
                    d_next       = in_day;
                    h_next       = in_item.hour;
                    m_next       = in_item.minute;
                    now_next     = time_of(mode_reg, in_day, in_item.hour,
                                           in_item.minute);
                    rd_idx_next  = '0;
                    found_next   = 1'b0;
                    result_next  = '{fired: 1'b0, fired_event: 1'b0,
                                     condition: cond_reg, entry_added: 1'b0};
                    unique case (in_item.operation)
                        OP_APPEND:
                        begin
                            done_next = 1'b1;
                            if (!table_full)
                            begin
                                wr_en                   = 1'b1;
                                count_next              = count_reg + CNT_W'(1);
                                result_next.entry_added = 1'b1;
                            end
                        end
                        OP_TICK:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        OP_RECOMPUTE:
                        begin
                            if (count_reg == '0)
                            begin
                                cond_next             = 1'b0;
                                result_next.condition = 1'b0;
                                done_next             = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                // Issue the next read while the previous entry is checked
                if (issue)
                begin
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                    pend_next   = 1'b1;
                end
                if (pend_reg)
                begin
                    if (is_tick_reg)
                    begin
                        if (tick_hit)
                        begin
                            cond_next   = rd_data_reg.ev;
                            result_next = '{fired: 1'b1, fired_event: rd_data_reg.ev,
                                            condition: rd_data_reg.ev,
                                            entry_added: 1'b0};
                            done_next   = 1'b1;
                            state_next  = ST_IDLE;
                        end
                        else if (!issue)
                        begin
                            done_next  = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                    else
                    begin
                        if (qualify)
                        begin
                            found_next   = 1'b1;
                            best_next    = ent_time;
                            best_ev_next = rd_data_reg.ev;
                        end
                        // Last entry: fall back to its event if nothing qualified
                        if (!issue)
                        begin
                            cond_next = found_next ? best_ev_next : rd_data_reg.ev;
                            result_next.condition = cond_next;
                            done_next  = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                end
                if (state_next == ST_IDLE)
                begin
                    pend_next = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            rd_idx_reg <= '0;
            pend_reg   <= 1'b0;
            cond_reg   <= 1'b0;
            mode_reg   <= 1'b0;
            found_reg  <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            rd_idx_reg <= rd_idx_next;
            pend_reg   <= pend_next;
            cond_reg   <= cond_next;
            found_reg  <= found_next;
            done_reg   <= done_next;
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        is_tick_reg <= is_tick_next;
        d_reg       <= d_next;
        h_reg       <= h_next;
        m_reg       <= m_next;
        now_reg     <= now_next;
        best_reg    <= best_next;
        best_ev_reg <= best_ev_next;
        result_reg  <= result_next;
    end

    // Table memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTH
    // Entry count never passes the table size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ENTRIES))
        else $error("entry count beyond table size");

    // An accepted append grows the table by exactly one
    a_added_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.entry_added) |-> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("entry added without count step");

    // Append items answer in the next cycle
    a_append_done: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (in_item.operation == OP_APPEND)) |=> done)
        else $error("append result missing");

    // No fired event without a fire
    a_fired_event: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.fired) |-> !result.fired_event)
        else $error("fired_event without fired");

    // The reported condition is the stored one
    a_cond_match: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.condition == cond_reg))
        else $error("result condition differs from state");
`endif

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench of weekly_time_switch_table_unit
// Items go in through the start/busy handshake and results come back on the
// done strobe. Each result is checked against a local model of the schedule
// table, condition and mode. Directed cases come first, then random traffic
// in daily and weekly mode with varying sender gaps.
// ----------------------------------------------------------------------------
module tb;

    import wtst_pkg::*;

    localparam logic [1:0] OP_UNUSED      = 2'd3;
    localparam int         DRAIN_CYCLES   = 40;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         MAX_REPORTS    = 10;
    localparam int         PHASE_ITEMS    = 430;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    in_item_t  in_item;
    logic      cfg_we;
    logic      cfg_wdata;
    logic      done;
    out_item_t result;

    // Model state: stored entries, fill level, condition and mode
    entry_t    sw_table [MAX_ENTRIES];
    int        sw_count;
    logic      sw_cond;
    logic      weekly_mode;

    out_item_t due_outcomes [$];
    int        gap_pct;
    int        errors;
    int        results_seen;
    int        n_append, n_dropped, n_tick, n_fired, n_recompute, n_unused;

    weekly_time_switch_table_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .in_item   (in_item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .done      (done),
        .result    (result)
    );

    // Clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Minutes since start of day, or of week in weekly mode
    function automatic int week_minutes(input logic [2:0] d, input logic [4:0] h,
                                        input logic [5:0] m);
        int t;
        t = int'(h) * 60 + int'(m);
        if (weekly_mode)
        begin
            t = t + int'(d) * 1440;
        end
        return t;
    endfunction

    // Applies one item to the model and returns the result it should give
    function automatic out_item_t schedule_outcome(input in_item_t it);
        out_item_t r;
        logic [2:0] d;
        logic       cond;
        logic       found;
        int         now;
        int         t;
        int         best;
        r = '0;
        d = (it.day == 3'd7) ? 3'd0 : it.day;
        case (it.operation)
            OP_APPEND:
            begin
                n_append++;
                if (sw_count < MAX_ENTRIES)
                begin
                    sw_table[sw_count] = '{day: d, hour: it.hour, minute: it.minute,
                                           ev: it.entry_event};
                    sw_count++;
                    r.entry_added = 1'b1;
                end
                else
                begin
                    n_dropped++;
                end
            end
            OP_TICK:
            begin
                n_tick++;
                // first matching entry wins
                for (int i = 0; i < sw_count; i++)
                begin
                    if (sw_table[i].hour == it.hour && sw_table[i].minute == it.minute
                        && (!weekly_mode || sw_table[i].day == d))
                    begin
                        r.fired       = 1'b1;
                        r.fired_event = sw_table[i].ev;
                        sw_cond       = sw_table[i].ev;
                        n_fired++;
                        break;
                    end
                end
            end
            OP_RECOMPUTE:
            begin
                n_recompute++;
                now   = week_minutes(d, it.hour, it.minute);
                cond  = (sw_count > 0) ? sw_table[sw_count-1].ev : 1'b0;
                found = 1'b0;
                best  = 0;
                // latest strictly earlier entry; ties keep the earliest appended
                for (int i = 0; i < sw_count; i++)
                begin
                    t = week_minutes(sw_table[i].day, sw_table[i].hour, sw_table[i].minute);
                    if (t < now && (!found || t > best))
                    begin
                        found = 1'b1;
                        best  = t;
                        cond  = sw_table[i].ev;
                    end
                end
                sw_cond = cond;
            end
            default:
            begin
                n_unused++;
            end
        endcase
        r.condition = sw_cond;
        return r;
    endfunction

    // Result checking and model update, sampled at the rising edge
    always @(posedge clk)
    begin : result_check
        out_item_t want;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                weekly_mode = cfg_wdata;
            end
            if (done)
            begin
                results_seen++;
                if (due_outcomes.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                    begin
                        $display("result %0d arrived with nothing pending: %b",
                                 results_seen, result);
                    end
                end
                else
                begin
                    want = due_outcomes.pop_front();
                    if (result.fired !== want.fired || result.fired_event !== want.fired_event
                        || result.condition !== want.condition
                        || result.entry_added !== want.entry_added)
                    begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                        begin
                            $display("result %0d mismatch (fired fired_event condition added):",
                                     results_seen);
                            $display("  expected %b %b %b %b, got %b %b %b %b",
                                     want.fired, want.fired_event, want.condition,
                                     want.entry_added, result.fired, result.fired_event,
                                     result.condition, result.entry_added);
                        end
                    end
                end
            end
            if (start && !busy)
            begin
                due_outcomes.push_back(schedule_outcome(in_item));
            end
        end
    end

    // Sends one item after a random gap and returns once it is taken
    task automatic send_item(input logic [1:0] op, input logic [2:0] d,
                             input logic [4:0] h, input logic [5:0] m, input logic ev);
        while ($urandom_range(99) < gap_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start               <= 1'b1;
        in_item.operation   <= op;
        in_item.day         <= d;
        in_item.hour        <= h;
        in_item.minute      <= m;
        in_item.entry_event <= ev;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
    endtask

    // Stops sending and waits until every pending result is in
    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        while (due_outcomes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(input logic weekly);
        drain_results();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= weekly;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Tick, recompute and unused code before anything is stored
    task automatic test_empty_table();
        gap_pct = 0;
        send_item(OP_TICK, 3'd2, 5'd13, 6'd0, 1'b0);
        send_item(OP_RECOMPUTE, 3'd6, 5'd23, 6'd59, 1'b1);
        send_item(OP_UNUSED, 3'd7, 5'd31, 6'd63, 1'b1);
    endtask

    // Day seven, time zero, out-of-range fields and two equal times
    task automatic test_append_special();
        send_item(OP_APPEND, 3'd7, 5'd0, 6'd0, 1'b1);
        send_item(OP_APPEND, 3'd3, 5'd31, 6'd63, 1'b0);
        send_item(OP_APPEND, 3'd0, 5'd12, 6'd30, 1'b1);
        send_item(OP_APPEND, 3'd5, 5'd12, 6'd30, 1'b0);
    endtask

    task automatic test_daily_queries();
        send_item(OP_RECOMPUTE, 3'd2, 5'd0, 6'd1, 1'b0);   // entry at time zero qualifies
        send_item(OP_RECOMPUTE, 3'd2, 5'd0, 6'd0, 1'b0);   // none earlier: last entry
        send_item(OP_TICK, 3'd5, 5'd12, 6'd30, 1'b0);      // day ignored, first match
        send_item(OP_RECOMPUTE, 3'd1, 5'd31, 6'd63, 1'b0); // equal times, earliest wins
        send_item(OP_TICK, 3'd1, 5'd31, 6'd63, 1'b1);      // out-of-range entry hit
        send_item(OP_TICK, 3'd1, 5'd5, 6'd5, 1'b0);        // no match keeps condition
    endtask

    task automatic test_weekly_queries();
        write_mode(1'b1);
        send_item(OP_TICK, 3'd5, 5'd12, 6'd30, 1'b0);
        send_item(OP_TICK, 3'd7, 5'd0, 6'd0, 1'b0);        // tick day seven is sunday
        send_item(OP_RECOMPUTE, 3'd7, 5'd0, 6'd0, 1'b1);   // start of week
        send_item(OP_RECOMPUTE, 3'd6, 5'd23, 6'd59, 1'b0); // end of week
        send_item(OP_RECOMPUTE, 3'd1, 5'd0, 6'd0, 1'b0);
    endtask

    // Random traffic, partly aimed at stored times so ticks hit and
    // recomputes land on and just past entries
    task automatic test_random_traffic(input int items, input int pct, input logic weekly);
        entry_t     pick;
        logic [1:0] op;
        logic [2:0] d;
        logic [4:0] h;
        logic [5:0] m;
        int         sel;
        write_mode(weekly);
        gap_pct = pct;
        for (int n = 0; n < items; n++)
        begin
            sel = $urandom_range(99);
            d   = 3'($urandom_range(7));
            h   = 5'($urandom_range(23));
            m   = 6'($urandom_range(59));
            if ($urandom_range(9) == 0)
            begin
                h = 5'($urandom_range(31));
                m = 6'($urandom_range(63));
            end
            pick = '0;
            if (sw_count > 0)
            begin
                pick = sw_table[$urandom_range(sw_count - 1)];
            end
            if (sel < 3)
            begin
                op = OP_UNUSED;
            end
            else if (sel < 20)
            begin
                op = OP_APPEND;
            end
            else if (sel < 60)
            begin
                op = OP_TICK;
            end
            else
            begin
                op = OP_RECOMPUTE;
            end
            // reuse a stored time: equal-time appends, hitting ticks, edge recomputes
            if ((op == OP_APPEND && sel < 8) || (op == OP_TICK && sel < 45)
                || (op == OP_RECOMPUTE && sel < 75))
            begin
                d = (pick.day == 3'd0 && $urandom_range(1) == 1) ? 3'd7 : pick.day;
                h = pick.hour;
                m = pick.minute;
                if (op == OP_RECOMPUTE)
                begin
                    m = m + 6'($urandom_range(1));
                end
            end
            send_item(op, d, h, m, 1'($urandom_range(1)));
        end
    endtask

    // Watchdog: ends the run if nothing moves for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || done)
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("timeout: no item or result for %0d cycles", WATCHDOG_LIMIT);
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        in_item     = '0;
        cfg_we      = 1'b0;
        cfg_wdata   = 1'b0;
        sw_count    = 0;
        sw_cond     = 1'b0;
        weekly_mode = 1'b0;
        gap_pct     = 0;
        errors      = 0;
        results_seen = 0;
        n_append    = 0;
        n_dropped   = 0;
        n_tick      = 0;
        n_fired     = 0;
        n_recompute = 0;
        n_unused    = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        test_empty_table();
        test_append_special();
        test_daily_queries();
        test_weekly_queries();
        test_random_traffic(PHASE_ITEMS, 0, 1'b0);
        test_random_traffic(PHASE_ITEMS, 84, 1'b1);
        test_random_traffic(PHASE_ITEMS, 9, 1'b0);
        test_random_traffic(PHASE_ITEMS, 0, 1'b1);
        drain_results();

        $display("Covered %0d results: %0d appends (%0d dropped on a full table), %0d ticks",
                 results_seen, n_append, n_dropped, n_tick);
        $display("(%0d matched), %0d recomputes, %0d unused codes; daily and weekly; %0d errors",
                 n_fired, n_recompute, n_unused, errors);
        if (errors == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
